@@ hdl/nobs_pkg.sv @@
package nobs_pkg;

  localparam int MAX_OBJECTS = 64;
  localparam int IDX_W       = $clog2(MAX_OBJECTS);
  localparam int COUNT_W     = 7;
  localparam int CRD_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int REC_W       = 4 * CRD_W + 1;

  localparam logic [CFG_W-1:0] REACH_SCALE_RST = 16'd4096;
  localparam logic             SKIP_BG_RST     = 1'b0;
  localparam logic             INC_STATIC_RST  = 1'b0;
  localparam logic             ABS_OFFS_RST    = 1'b1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REACH_SCALE = 2'd0,
    CFG_SKIP_BG     = 2'd1,
    CFG_INC_STATIC  = 2'd2,
    CFG_ABS_OFFS    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBJ_RD,
    ST_SUBJ_LD,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             ram_we;
    logic [IDX_W-1:0] rd_addr;
    logic             issue;
    logic             subj_load;
    logic             clear_best;
    logic             div_start;
    logic             load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
    logic have;
  } dp_stat_t;

endpackage

@@ hdl/nobs_ram.sv @@
module nobs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/nobs_div.sv @@
module nobs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] num,
  input  logic [15:0]        den,
  output logic               busy,
  output logic signed [15:0] quot
);

  // Quotient bits left after the saturation check rules out q >= 2^15
  localparam int STEPS  = 15;
  localparam int STEP_W = $clog2(STEPS);

  logic [16:0]       num_abs;
  logic [15:0]       mag;
  logic [16:0]       rem;
  logic [16:0]       trial;
  logic [16:0]       rem_next;
  logic              qbit;
  logic [STEPS-1:0]  low;
  logic [STEPS-1:0]  quo;
  logic [STEPS-1:0]  quo_next;
  logic [15:0]       den_q;
  logic              neg;
  logic [STEP_W-1:0] step;

  assign num_abs = num[16] ? 17'(-num) : num;
  assign mag     = num_abs[15:0];

  always_comb begin
    trial = {rem[15:0], low[STEPS-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_next = qbit ? 17'(trial - {1'b0, den_q}) : trial;
    quo_next = {quo[STEPS-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b0;
      neg  <= num[16];
      priority if (mag == 16'd0) begin
        quot <= '0;
      end else if ({7'b0, mag} >= {den, 7'b0}) begin
        quot <= num[16] ? 16'sh8000 : 16'sh7FFF;
      end else begin
        busy  <= 1'b1;
        rem   <= {8'b0, mag[15:7]};
        low   <= {mag[6:0], 8'b0};
        quo   <= '0;
        den_q <= den;
        step  <= '0;
      end
    end else if (busy) begin
      rem  <= rem_next;
      low  <= {low[STEPS-2:0], 1'b0};
      quo  <= quo_next;
      step <= STEP_W'(step + 1'b1);
      if (step == STEP_W'(STEPS - 1)) begin
        busy <= 1'b0;
        quot <= neg ? 16'(-{1'b0, quo_next}) : {1'b0, quo_next};
      end
    end
  end

endmodule

@@ hdl/nobs_datapath.sv @@
module nobs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  nobs_pkg::dp_cmd_t             ctl,
  output nobs_pkg::dp_stat_t            stat,
  input  logic [nobs_pkg::IDX_W-1:0]    slot,
  input  logic signed [15:0]            center_x,
  input  logic signed [15:0]            center_y,
  input  logic [15:0]                   size_x,
  input  logic [15:0]                   size_y,
  input  logic                          dynamic,
  input  logic [nobs_pkg::CFG_W-1:0]    reach_scale,
  input  logic                          include_static,
  input  logic                          absolute_offsets,
  output logic                          found,
  output logic [nobs_pkg::IDX_W-1:0]    partner_index,
  output logic signed [15:0]            offset_x,
  output logic signed [15:0]            offset_y
);

  import nobs_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v[16] != v[15]) begin
      return v[16] ? 16'sh8000 : 16'sh7FFF;
    end
    return $signed(v[15:0]);
  endfunction

  logic [REC_W-1:0] wr_rec;
  logic [REC_W-1:0] rd_rec;

  assign wr_rec = {dynamic, size_y, size_x, center_y, center_x};

  nobs_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_OBJECTS)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.ram_we),
    .waddr(slot),
    .wdata(wr_rec),
    .raddr(ctl.rd_addr),
    .rdata(rd_rec)
  );

  logic signed [15:0] rd_cx, rd_cy;
  logic [15:0]        rd_w, rd_h;
  logic               rd_dyn;

  assign rd_cx  = $signed(rd_rec[15:0]);
  assign rd_cy  = $signed(rd_rec[31:16]);
  assign rd_w   = rd_rec[47:32];
  assign rd_h   = rd_rec[63:48];
  assign rd_dyn = rd_rec[64];

  // Subject record
  logic signed [15:0] sub_cx, sub_cy;
  logic [15:0]        sub_w, sub_h;

  always_ff @(posedge clk) begin
    if (ctl.subj_load) begin
      sub_cx <= rd_cx;
      sub_cy <= rd_cy;
      sub_w  <= rd_w;
      sub_h  <= rd_h;
    end
  end

  // Scan pipeline: read, difference, multiply, test, select
  logic             p0_valid;
  logic [IDX_W-1:0] p0_idx;

  logic               s1_valid;
  logic [IDX_W-1:0]   s1_idx;
  logic signed [16:0] s1_dx, s1_dy;
  logic [16:0]        s1_sumw, s1_sumh;
  logic               s1_dyn;

  logic [16:0] s1_ax, s1_ay;

  logic               s2_valid;
  logic [IDX_W-1:0]   s2_idx;
  logic signed [16:0] s2_dx, s2_dy;
  logic [15:0]        s2_gx, s2_gy;
  logic [32:0]        s2_px, s2_py;
  logic [31:0]        s2_dx2, s2_dy2;
  logic               s2_dyn;

  logic               s3_keep;
  logic [IDX_W-1:0]   s3_idx;
  logic signed [16:0] s3_dx, s3_dy;
  logic [32:0]        s3_d2;

  logic               have;
  logic [32:0]        best_d2;
  logic [IDX_W-1:0]   best_slot;
  logic signed [16:0] best_dx, best_dy;

  assign s1_ax = s1_dx[16] ? 17'(-s1_dx) : s1_dx;
  assign s1_ay = s1_dy[16] ? 17'(-s1_dy) : s1_dy;

  always_ff @(posedge clk) begin
    p0_idx  <= ctl.rd_addr;

    s1_idx  <= p0_idx;
    s1_dx   <= 17'({sub_cx[15], sub_cx} - {rd_cx[15], rd_cx});
    s1_dy   <= 17'({sub_cy[15], sub_cy} - {rd_cy[15], rd_cy});
    s1_sumw <= 17'({1'b0, sub_w} + {1'b0, rd_w});
    s1_sumh <= 17'({1'b0, sub_h} + {1'b0, rd_h});
    s1_dyn  <= rd_dyn;

    s2_idx  <= s1_idx;
    s2_dx   <= s1_dx;
    s2_dy   <= s1_dy;
    s2_gx   <= s1_ax[15:0];
    s2_gy   <= s1_ay[15:0];
    s2_px   <= {16'b0, s1_sumw} * {17'b0, reach_scale};
    s2_py   <= {16'b0, s1_sumh} * {17'b0, reach_scale};
    s2_dx2  <= s1_ax[15:0] * s1_ax[15:0];
    s2_dy2  <= s1_ay[15:0] * s1_ay[15:0];
    s2_dyn  <= s1_dyn;

    s3_idx  <= s2_idx;
    s3_dx   <= s2_dx;
    s3_dy   <= s2_dy;
    s3_d2   <= {1'b0, s2_dx2} + {1'b0, s2_dy2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_keep  <= 1'b0;
      have     <= 1'b0;
    end else begin
      p0_valid <= ctl.issue;
      s1_valid <= p0_valid;
      s2_valid <= s1_valid;
      s3_keep  <= s2_valid
                  && ({5'b0, s2_gx, 12'b0} < s2_px)
                  && ({5'b0, s2_gy, 12'b0} < s2_py)
                  && (s2_dyn || include_static);
      if (ctl.clear_best) begin
        have <= 1'b0;
      end else if (s3_keep && (!have || s3_d2 < best_d2)) begin
        have <= 1'b1;
      end
    end
  end

  // Strict compare keeps the earliest slot on equal distance
  always_ff @(posedge clk) begin
    if (s3_keep && (!have || s3_d2 < best_d2)) begin
      best_d2   <= s3_d2;
      best_slot <= s3_idx;
      best_dx   <= s3_dx;
      best_dy   <= s3_dy;
    end
  end

  logic               div_busy_x, div_busy_y;
  logic signed [15:0] div_qx, div_qy;

  nobs_div u_div_x (
    .clk  (clk),
    .rst  (rst),
    .start(ctl.div_start),
    .num  (best_dx),
    .den  (sub_w),
    .busy (div_busy_x),
    .quot (div_qx)
  );

  nobs_div u_div_y (
    .clk  (clk),
    .rst  (rst),
    .start(ctl.div_start),
    .num  (best_dy),
    .den  (sub_h),
    .busy (div_busy_y),
    .quot (div_qy)
  );

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      found <= have;
      if (!have) begin
        partner_index <= '0;
        offset_x      <= '0;
        offset_y      <= '0;
      end else begin
        partner_index <= best_slot;
        offset_x      <= absolute_offsets ? sat16(best_dx) : div_qx;
        offset_y      <= absolute_offsets ? sat16(best_dy) : div_qy;
      end
    end
  end

  assign stat.pipe_busy = p0_valid | s1_valid | s2_valid | s3_keep;
  assign stat.div_busy  = div_busy_x | div_busy_y;
  assign stat.have      = have;

endmodule

@@ hdl/nobs_ctrl.sv @@
module nobs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [nobs_pkg::IDX_W-1:0]    slot,
  input  logic [nobs_pkg::COUNT_W-1:0]  object_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          skip_background,
  input  logic                          absolute_offsets,
  input  nobs_pkg::dp_stat_t            stat,
  output nobs_pkg::dp_cmd_t             ctl
);

  import nobs_pkg::*;

  state_t             state, state_next;
  logic [IDX_W-1:0]   q_slot;
  logic [COUNT_W-1:0] q_cnt;
  logic [COUNT_W-1:0] j, j_next;
  logic               accept;
  logic               skip;
  logic               out_free;

  assign accept   = in_valid && (state == ST_IDLE);
  assign skip     = (j[IDX_W-1:0] == q_slot) || (skip_background && j == '0);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    j <= j_next;
    if (accept && cmd == CMD_QUERY) begin
      q_slot <= slot;
      q_cnt  <= (object_count > COUNT_W'(MAX_OBJECTS)) ? COUNT_W'(MAX_OBJECTS)
                                                        : object_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next     = state;
    j_next         = j;
    ctl            = '0;
    ctl.rd_addr    = q_slot;
    ctl.ram_we     = accept && cmd == CMD_WRITE;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_QUERY) begin
          state_next = ST_SUBJ_RD;
        end
      end
      ST_SUBJ_RD: begin
        ctl.clear_best = 1'b1;
        state_next     = ST_SUBJ_LD;
      end
      ST_SUBJ_LD: begin
        ctl.subj_load = 1'b1;
        j_next        = '0;
        state_next    = (q_cnt == '0) ? ST_DRAIN : ST_SCAN;
      end
      ST_SCAN: begin
        ctl.rd_addr = j[IDX_W-1:0];
        ctl.issue   = !skip;
        j_next      = COUNT_W'(j + 1'b1);
        if (COUNT_W'(j + 1'b1) == q_cnt) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = (stat.have && !absolute_offsets) ? ST_DIV_GO : ST_FINISH;
        end
      end
      ST_DIV_GO: begin
        ctl.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat.div_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (j < q_cnt))
    else $error("scan index past object count");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_QUERY) |=> (state == ST_SUBJ_RD))
    else $error("accepted query did not start subject read");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_WRITE) |=> (state == ST_IDLE))
    else $error("write request left the idle state");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> out_valid)
    else $error("finished query produced no result");

endmodule

@@ hdl/nearest_overlapping_box_search_unit.sv @@
// Nearest overlapping box search. Write requests (cmd 0) store an object's
// center, size and dynamic flag in one of 64 slots. A query request (cmd 1)
// reads the subject slot, then scans slots 0 to min(object_count, 64)-1
// through the single read port of the object memory, one slot per cycle,
// and picks the nearest overlapping partner. With size-scaled offsets the
// bit-serial dividers run after the scan. The next request is taken while
// the previous result waits in the output register.
// Configuration writes must only be issued while no query is in flight.
module nearest_overlapping_box_search_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [nobs_pkg::IDX_W-1:0]      slot,
  input  logic signed [15:0]              center_x,
  input  logic signed [15:0]              center_y,
  input  logic [15:0]                     size_x,
  input  logic [15:0]                     size_y,
  input  logic                            dynamic,
  input  logic [nobs_pkg::COUNT_W-1:0]    object_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [nobs_pkg::IDX_W-1:0]      partner_index,
  output logic signed [15:0]              offset_x,
  output logic signed [15:0]              offset_y,
  input  logic                            cfg_we,
  input  logic [nobs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nobs_pkg::CFG_W-1:0]      cfg_data
);

  import nobs_pkg::*;

  logic [CFG_W-1:0] reach_scale;
  logic             skip_background;
  logic             include_static;
  logic             absolute_offsets;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_scale      <= REACH_SCALE_RST;
      skip_background  <= SKIP_BG_RST;
      include_static   <= INC_STATIC_RST;
      absolute_offsets <= ABS_OFFS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REACH_SCALE: reach_scale      <= cfg_data;
        CFG_SKIP_BG:     skip_background  <= cfg_data[0];
        CFG_INC_STATIC:  include_static   <= cfg_data[0];
        CFG_ABS_OFFS:    absolute_offsets <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  nobs_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .slot            (slot),
    .object_count    (object_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .skip_background (skip_background),
    .absolute_offsets(absolute_offsets),
    .stat            (stat),
    .ctl             (ctl)
  );

  nobs_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .slot            (slot),
    .center_x        (center_x),
    .center_y        (center_y),
    .size_x          (size_x),
    .size_y          (size_y),
    .dynamic         (dynamic),
    .reach_scale     (reach_scale),
    .include_static  (include_static),
    .absolute_offsets(absolute_offsets),
    .found           (found),
    .partner_index   (partner_index),
    .offset_x        (offset_x),
    .offset_y        (offset_y)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import nobs_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int PHASE_ITEMS   = 105;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    cmd_t                 op;
    logic [IDX_W-1:0]     slot;
    logic signed [15:0]   cx;
    logic signed [15:0]   cy;
    logic [15:0]          sx;
    logic [15:0]          sy;
    logic                 dyn;
    logic [COUNT_W-1:0]   count;
  } request_t;

  typedef struct {
    logic                 found;
    logic [IDX_W-1:0]     partner;
    logic signed [15:0]   ox;
    logic signed [15:0]   oy;
  } partner_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     cmd = 1'b0;
  logic [IDX_W-1:0]         slot = '0;
  logic signed [15:0]       center_x = '0;
  logic signed [15:0]       center_y = '0;
  logic [15:0]              size_x = '0;
  logic [15:0]              size_y = '0;
  logic                     dynamic = 1'b0;
  logic [COUNT_W-1:0]       object_count = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [IDX_W-1:0]         partner_index;
  logic signed [15:0]       offset_x;
  logic signed [15:0]       offset_y;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_REACH_SCALE;
  logic [CFG_W-1:0]         cfg_data = '0;

  // object table and registers as the block should hold them
  logic signed [15:0]       obj_cx [MAX_OBJECTS];
  logic signed [15:0]       obj_cy [MAX_OBJECTS];
  logic [15:0]              obj_sx [MAX_OBJECTS];
  logic [15:0]              obj_sy [MAX_OBJECTS];
  logic                     obj_dyn [MAX_OBJECTS];
  logic [15:0]              reach_q412 = REACH_SCALE_RST;
  logic                     skip_slot0 = SKIP_BG_RST;
  logic                     allow_static = INC_STATIC_RST;
  logic                     raw_offsets = ABS_OFFS_RST;

  request_t                 pending_requests [$];
  partner_t                 expected_partners [$];
  request_t                 next_req;
  partner_t                 want;
  bit [MAX_OBJECTS-1:0]     filled = '0;
  int                       offered_n = 0;
  int                       taken_n = 0;
  int                       gap_pct = 0;
  int                       stall_pct = 0;
  int                       failures = 0;
  int                       cycles = 0;

  nearest_overlapping_box_search_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .slot(slot), .center_x(center_x), .center_y(center_y),
    .size_x(size_x), .size_y(size_y), .dynamic(dynamic), .object_count(object_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .partner_index(partner_index), .offset_x(offset_x), .offset_y(offset_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      obj_cx[i] = '0;
      obj_cy[i] = '0;
      obj_sx[i] = '0;
      obj_sy[i] = '0;
      obj_dyn[i] = 1'b0;
    end
  end

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] div_by_size(longint d, logic [15:0] sz);
    longint unsigned mag;
    longint unsigned quo;
    if (sz == 0) begin
      if (d > 0) return 16'sh7FFF;
      if (d < 0) return 16'sh8000;
      return 16'sh0000;
    end
    mag = (d < 0) ? -d : d;
    quo = (mag << 8) / sz;
    return (d < 0) ? clamp16(-longint'(quo)) : clamp16(longint'(quo));
  endfunction

  function automatic partner_t find_partner(logic [IDX_W-1:0] subj, logic [COUNT_W-1:0] cnt);
    partner_t        r;
    int              n;
    longint          xi, yi, dx, dy, gx, gy;
    longint unsigned wi, hi, d2, best_d2;
    r.found = 1'b0;
    r.partner = '0;
    r.ox = '0;
    r.oy = '0;
    best_d2 = 0;
    n = (cnt > MAX_OBJECTS) ? MAX_OBJECTS : cnt;
    xi = obj_cx[subj];
    yi = obj_cy[subj];
    wi = obj_sx[subj];
    hi = obj_sy[subj];
    for (int j = 0; j < n; j++) begin
      if (j != subj && !(skip_slot0 && j == 0)) begin
        dx = xi - longint'(obj_cx[j]);
        dy = yi - longint'(obj_cy[j]);
        gx = (dx < 0) ? -dx : dx;
        gy = (dy < 0) ? -dy : dy;
        // overlap on both axes, strict, against scaled size sum
        if (longint'(gx << 12) < longint'((wi + obj_sx[j]) * reach_q412) &&
            longint'(gy << 12) < longint'((hi + obj_sy[j]) * reach_q412) &&
            (obj_dyn[j] || allow_static)) begin
          d2 = dx * dx + dy * dy;
          if (!r.found || d2 < best_d2) begin
            r.found = 1'b1;
            best_d2 = d2;
            r.partner = j[IDX_W-1:0];
            if (raw_offsets) begin
              r.ox = clamp16(dx);
              r.oy = clamp16(dy);
            end else begin
              r.ox = div_by_size(dx, obj_sx[subj]);
              r.oy = div_by_size(dy, obj_sy[subj]);
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void queue_object(int s, int cx, int cy, int sx, int sy, bit dyn);
    request_t r;
    r.op = CMD_WRITE;
    r.slot = s[IDX_W-1:0];
    r.cx = cx[15:0];
    r.cy = cy[15:0];
    r.sx = sx[15:0];
    r.sy = sy[15:0];
    r.dyn = dyn;
    r.count = COUNT_W'($urandom);
    filled[s] = 1'b1;
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void queue_query(int s, int cnt);
    request_t r;
    r.op = CMD_QUERY;
    r.slot = s[IDX_W-1:0];
    r.cx = 16'($urandom);
    r.cy = 16'($urandom);
    r.sx = 16'($urandom);
    r.sy = 16'($urandom);
    r.dyn = 1'($urandom);
    r.count = cnt[COUNT_W-1:0];
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int edge_size();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 1;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic void queue_random_object(int s);
    int  kind;
    int  cx, cy, sx, sy;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // tight cluster near the origin so boxes overlap; grid points give ties
      if ($urandom_range(0, 1)) begin
        cx = $urandom_range(0, 8) * 16'h80 - 16'h200;
        cy = $urandom_range(0, 8) * 16'h80 - 16'h200;
      end else begin
        cx = $urandom_range(0, 16'h800) - 16'h400;
        cy = $urandom_range(0, 16'h800) - 16'h400;
      end
      sx = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(16'h40, 16'h600);
      sy = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(16'h40, 16'h600);
    end else if (kind < 8) begin
      cx = $urandom;
      cy = $urandom;
      sx = $urandom;
      sy = $urandom;
    end else begin
      cx = edge_coord();
      cy = edge_coord();
      sx = edge_size();
      sy = edge_size();
    end
    queue_object(s, cx, cy, sx, sy, $urandom_range(0, 3) != 0);
  endfunction

  function automatic void add_random_request();
    int s;
    int maxc;
    int roll;
    int cnt;
    if ($urandom_range(0, 1) == 0) begin
      // fill the table from the bottom so queries can scan far
      s = 0;
      while (s < MAX_OBJECTS && filled[s]) s++;
      if (s == MAX_OBJECTS || $urandom_range(0, 1)) s = $urandom_range(0, MAX_OBJECTS - 1);
      queue_random_object(s);
    end else begin
      do s = $urandom_range(0, MAX_OBJECTS - 1); while (!filled[s]);
      // never scan a slot that has not been written
      maxc = 0;
      while (maxc < MAX_OBJECTS && (filled[maxc] || maxc == s || (skip_slot0 && maxc == 0)))
        maxc++;
      roll = $urandom_range(0, 9);
      if (roll == 0 || maxc == 0) cnt = 0;
      else if (roll == 1 && maxc == MAX_OBJECTS) cnt = $urandom_range(MAX_OBJECTS, 127);
      else cnt = $urandom_range(1, maxc);
      queue_query(s, cnt);
    end
  endfunction

  task automatic settle();
    while (pending_requests.size() != 0 || taken_n != offered_n ||
           expected_partners.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_registers(logic [15:0] reach, logic skip, logic stat, logic raw);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_REACH_SCALE;
    cfg_data <= reach;
    @(negedge clk);
    cfg_index <= CFG_SKIP_BG;
    cfg_data <= {15'd0, skip};
    @(negedge clk);
    cfg_index <= CFG_INC_STATIC;
    cfg_data <= {15'd0, stat};
    @(negedge clk);
    cfg_index <= CFG_ABS_OFFS;
    cfg_data <= {15'd0, raw};
    @(negedge clk);
    cfg_we <= 1'b0;
    reach_q412 = reach;
    skip_slot0 = skip;
    allow_static = stat;
    raw_offsets = raw;
  endtask

  task automatic run_phase(logic [15:0] reach, logic skip, logic stat, logic raw,
                           int gap, int stall);
    set_registers(reach, skip, stat, raw);
    gap_pct = gap;
    stall_pct = stall;
    repeat (PHASE_ITEMS) add_random_request();
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // far corners: in reach of each other, offsets saturate
    queue_object(0, 32767, 32767, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_object(1, -32768, -32768, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_object(2, 0, 0, 16'h400, 16'h400, 1'b1);
    // equal distance from slot 2: lower slot must win
    queue_object(3, 16'h100, 16'h100, 16'h200, 16'h200, 1'b1);
    queue_object(4, -16'h100, -16'h100, 16'h200, 16'h200, 1'b1);
    // closest to slot 2 but static
    queue_object(5, 16'h80, 0, 16'h100, 16'h100, 1'b0);
    queue_object(6, 16'h300, 0, 0, 0, 1'b1);
    queue_object(63, 16'h10, 16'h10, 16'h800, 16'h800, 1'b1);
    queue_query(1, 2);
    queue_query(0, 2);
    queue_query(2, 7);
    queue_query(6, 7);
    queue_query(2, 0);
    queue_query(3, 1);
    queue_query(63, 7);
    settle();

    // scaled offsets, static partners, slot 0 skipped; slot 6 has zero size
    set_registers(16'd4096, 1'b1, 1'b1, 1'b0);
    queue_query(2, 7);
    queue_query(6, 7);
    queue_query(1, 2);
    queue_query(3, 7);
    queue_query(4, 7);
    settle();

    run_phase(16'hFFFF, 1'b1, 1'b1, 1'b0, 0, 0);
    run_phase(16'd0, 1'b0, 1'b1, 1'b1, 88, 0);
    run_phase(16'd2048, 1'b0, 1'b0, 1'b0, 0, 88);
    run_phase(16'd12000, 1'b1, 1'b1, 1'b1, 20, 20);
    run_phase(16'd4096, 1'b0, 1'b1, 1'b0, 88, 0);
    run_phase(16'd30000, 1'b0, 1'b0, 1'b1, 0, 88);
    run_phase(16'd4096, 1'b1, 1'b1, 1'b1, 0, 0);

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // request driver and result-side stall
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (taken_n == offered_n) begin
        if (pending_requests.size() != 0 && !($urandom_range(0, 99) < gap_pct)) begin
          next_req = pending_requests.pop_front();
          cmd <= next_req.op;
          slot <= next_req.slot;
          center_x <= next_req.cx;
          center_y <= next_req.cy;
          size_x <= next_req.sx;
          size_y <= next_req.sy;
          dynamic <= next_req.dyn;
          object_count <= next_req.count;
          in_valid <= 1'b1;
          offered_n <= offered_n + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // apply each accepted request to the table, predict the query answer
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (cmd == CMD_WRITE) begin
        obj_cx[slot] = center_x;
        obj_cy[slot] = center_y;
        obj_sx[slot] = size_x;
        obj_sy[slot] = size_y;
        obj_dyn[slot] = dynamic;
      end else begin
        expected_partners.insert(expected_partners.size(), find_partner(slot, object_count));
      end
      taken_n <= taken_n + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_partners.size() == 0) begin
        if (failures < REPORT_MAX)
          $display("unexpected result: found %0d partner %0d offset %0d,%0d",
                   found, partner_index, offset_x, offset_y);
        failures <= failures + 1;
      end else begin
        want = expected_partners.pop_front();
        if (found !== want.found || partner_index !== want.partner ||
            offset_x !== want.ox || offset_y !== want.oy) begin
          if (failures < REPORT_MAX)
            $display("mismatch: expected found %0d partner %0d offset %0d,%0d; got %0d %0d %0d,%0d",
                     want.found, want.partner, want.ox, want.oy,
                     found, partner_index, offset_x, offset_y);
          failures <= failures + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
